FILE: hdl/kplsc_pkg.sv
package kplsc_pkg;

	localparam int NUM_KEYS   = 8;
	localparam int COUNT_BITS = 16;
	localparam int FIELD_KEYS = 8;
	localparam int TIME_W     = 16;
	localparam int MASK_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int KEY_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int CMP_W      = (COUNT_BITS > TIME_W) ? COUNT_BITS : TIME_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LONG_TIME     = 3'd0,
		CFG_SHORT_TIME    = 3'd1,
		CFG_MAX_TIME      = 3'd2,
		CFG_REPEAT_DELAY  = 3'd3,
		CFG_REPEAT_MASK   = 3'd4,
		CFG_HOLD_MASK     = 3'd5,
		CFG_CLASSIFY_MASK = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] long_time;
		logic [TIME_W-1:0] short_time;
		logic [TIME_W-1:0] max_time;
		logic [TIME_W-1:0] repeat_delay;
		logic [MASK_W-1:0] repeat_mask;
		logic [MASK_W-1:0] hold_mask;
		logic [MASK_W-1:0] classify_mask;
	} cfg_t;

	typedef struct packed {
		logic             step;
		logic             last;
		logic [KEY_W-1:0] key;
		logic             load_out;
		logic             accept;
	} ctrl_t;

	typedef struct packed {
		logic                  lv;
		logic                  armed;
		logic [COUNT_BITS-1:0] cnt;
		logic                  last_p;
		logic                  last_l;
		logic                  cls;
		logic                  hold;
		logic                  rpt;
		logic                  timer_zero;
	} key_in_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] cnt;
		logic                  armed;
		logic                  last_p;
		logic                  last_l;
		logic                  reload;
	} key_upd_t;

	function automatic logic [NUM_KEYS-1:0] widen_keys(input logic [FIELD_KEYS-1:0] v);
		logic [NUM_KEYS-1:0] r;
		r = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			r[i] = (i < FIELD_KEYS) ? v[i % FIELD_KEYS] : 1'b0;
		end
		return r;
	endfunction

	function automatic logic [FIELD_KEYS-1:0] narrow_keys(input logic [NUM_KEYS-1:0] v);
		logic [FIELD_KEYS-1:0] r;
		r = '0;
		for (int i = 0; i < FIELD_KEYS; i++) begin
			r[i] = (i < NUM_KEYS) ? v[i % NUM_KEYS] : 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: hdl/kplsc_key_unit.sv
module kplsc_key_unit (
	input  logic              scan,
	input  kplsc_pkg::cfg_t    cfg,
	input  kplsc_pkg::key_in_t ki,
	output kplsc_pkg::key_upd_t ku
);

	logic [kplsc_pkg::CMP_W-1:0] cnt_w;
	logic ge_long;
	logic ge_short;
	logic below_max;
	logic not_sat;

	assign cnt_w     = kplsc_pkg::CMP_W'(ki.cnt);
	assign ge_long   = cnt_w >= kplsc_pkg::CMP_W'(cfg.long_time);
	assign ge_short  = cnt_w >= kplsc_pkg::CMP_W'(cfg.short_time);
	assign below_max = cnt_w < kplsc_pkg::CMP_W'(cfg.max_time);
	assign not_sat   = ki.cnt != {kplsc_pkg::COUNT_BITS{1'b1}};

	always_comb begin
		ku.cnt    = ki.cnt;
		ku.armed  = ki.armed;
		ku.last_p = ki.last_p;
		ku.last_l = ki.last_l;
		ku.reload = 1'b0;
		if (!scan) begin
			if (ki.lv && ki.armed && below_max && not_sat) begin
				ku.cnt = ki.cnt + 1'b1;
			end
			if (!ki.lv) begin
				ku.armed = 1'b1;
			end
		end else if (ki.cls) begin
			if (ki.armed && ge_long) begin
				ku.cnt    = '0;
				ku.armed  = 1'b0;
				ku.last_p = 1'b1;
				ku.last_l = 1'b1;
				ku.reload = 1'b1;
			end else if (ki.armed && !ki.lv && ge_short) begin
				ku.cnt    = '0;
				ku.armed  = 1'b0;
				ku.last_p = 1'b1;
				ku.last_l = 1'b0;
				ku.reload = 1'b1;
			end else if (!ki.lv && !ge_short) begin
				ku.cnt    = '0;
				ku.last_p = 1'b0;
				ku.last_l = 1'b0;
			end else if (!ki.armed && ki.hold) begin
				ku.last_p = ki.last_p;
			end else if (!ki.armed && ki.rpt && ki.timer_zero) begin
				ku.reload = 1'b1;
				ku.last_p = 1'b1;
				ku.last_l = 1'b0;
			end else begin
				ku.last_p = 1'b0;
				ku.last_l = 1'b0;
			end
		end
	end

endmodule

FILE: hdl/kplsc_ctrl.sv
module kplsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              scan,
	input  logic              out_free,
	output logic              busy,
	output kplsc_pkg::ctrl_t  ctl
);

	kplsc_pkg::state_t state_q;
	kplsc_pkg::state_t state_d;
	logic [kplsc_pkg::KEY_W-1:0] key_q;
	logic last;

	assign last = key_q == kplsc_pkg::KEY_W'(kplsc_pkg::NUM_KEYS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kplsc_pkg::ST_IDLE: begin
				if (in_valid) state_d = kplsc_pkg::ST_WALK;
			end
			kplsc_pkg::ST_WALK: begin
				if (last) state_d = scan ? kplsc_pkg::ST_FINISH : kplsc_pkg::ST_IDLE;
			end
			kplsc_pkg::ST_FINISH: begin
				if (out_free) state_d = kplsc_pkg::ST_IDLE;
			end
			default: state_d = kplsc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy         = 1'b1;
		ctl.accept   = 1'b0;
		ctl.step     = 1'b0;
		ctl.load_out = 1'b0;
		ctl.last     = last;
		ctl.key      = key_q;
		unique case (state_q)
			kplsc_pkg::ST_IDLE: begin
				busy       = 1'b0;
				ctl.accept = in_valid;
			end
			kplsc_pkg::ST_WALK:   ctl.step = 1'b1;
			kplsc_pkg::ST_FINISH: ctl.load_out = out_free;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kplsc_pkg::ST_IDLE;
			key_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.accept) key_q <= '0;
			else if (ctl.step && !last) key_q <= key_q + 1'b1;
		end
	end

endmodule

FILE: hdl/key_press_long_short_classifier_top.sv
// Key classifier: a tick item advances the press counter of each armed, pressed key below
// max_time and the shared repeat timer, a scan item classifies the keys in the classify
// mask and returns one pair of masks. One evaluation unit visits a single key per cycle, so
// after its transaction an item holds the input stalled while the unit walks all NUM_KEYS
// keys, and a scan then holds it through a finish state, where its result also waits
// behind an earlier result that is still stalled at the output.
module key_press_long_short_classifier_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [kplsc_pkg::FIELD_KEYS-1:0]  key_levels,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [kplsc_pkg::FIELD_KEYS-1:0]  pressed_mask,
	output logic [kplsc_pkg::FIELD_KEYS-1:0]  long_mask,
	input  logic                              cfg_we,
	input  logic [kplsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kplsc_pkg::TIME_W-1:0]      cfg_data
);

	kplsc_pkg::cfg_t     cfg_q;
	kplsc_pkg::ctrl_t    ctl;
	kplsc_pkg::key_in_t  ki;
	kplsc_pkg::key_upd_t ku;

	logic [kplsc_pkg::COUNT_BITS-1:0] cnt_q [kplsc_pkg::NUM_KEYS];
	logic [kplsc_pkg::NUM_KEYS-1:0]   armed_q;
	logic [kplsc_pkg::NUM_KEYS-1:0]   last_p_q;
	logic [kplsc_pkg::NUM_KEYS-1:0]   last_l_q;
	logic [kplsc_pkg::NUM_KEYS-1:0]   lv_q;
	logic [kplsc_pkg::TIME_W-1:0]     timer_q;
	logic                             scan_q;
	logic                             out_valid_q;
	logic                             out_free;
	logic [kplsc_pkg::NUM_KEYS-1:0]   cls_v;
	logic [kplsc_pkg::NUM_KEYS-1:0]   hold_v;
	logic [kplsc_pkg::NUM_KEYS-1:0]   rpt_v;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign cls_v  = kplsc_pkg::widen_keys(cfg_q.classify_mask);
	assign hold_v = kplsc_pkg::widen_keys(cfg_q.hold_mask);
	assign rpt_v  = kplsc_pkg::widen_keys(cfg_q.repeat_mask);

	kplsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.scan     (scan_q),
		.out_free (out_free),
		.busy     (in_stall),
		.ctl      (ctl)
	);

	always_comb begin
		ki.lv         = lv_q[ctl.key];
		ki.armed      = armed_q[ctl.key];
		ki.cnt        = cnt_q[ctl.key];
		ki.last_p     = last_p_q[ctl.key];
		ki.last_l     = last_l_q[ctl.key];
		ki.cls        = cls_v[ctl.key];
		ki.hold       = hold_v[ctl.key];
		ki.rpt        = rpt_v[ctl.key];
		ki.timer_zero = timer_q == '0;
	end

	kplsc_key_unit u_key_unit (
		.scan (scan_q),
		.cfg  (cfg_q),
		.ki   (ki),
		.ku   (ku)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_time     <= 16'd100;
			cfg_q.short_time    <= 16'd3;
			cfg_q.max_time      <= 16'd1000;
			cfg_q.repeat_delay  <= 16'd10;
			cfg_q.repeat_mask   <= '0;
			cfg_q.hold_mask     <= '0;
			cfg_q.classify_mask <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kplsc_pkg::CFG_LONG_TIME:     cfg_q.long_time     <= cfg_data;
				kplsc_pkg::CFG_SHORT_TIME:    cfg_q.short_time    <= cfg_data;
				kplsc_pkg::CFG_MAX_TIME:      cfg_q.max_time      <= cfg_data;
				kplsc_pkg::CFG_REPEAT_DELAY:  cfg_q.repeat_delay  <= cfg_data;
				kplsc_pkg::CFG_REPEAT_MASK:   cfg_q.repeat_mask   <= cfg_data[kplsc_pkg::MASK_W-1:0];
				kplsc_pkg::CFG_HOLD_MASK:     cfg_q.hold_mask     <= cfg_data[kplsc_pkg::MASK_W-1:0];
				kplsc_pkg::CFG_CLASSIFY_MASK: cfg_q.classify_mask <= cfg_data[kplsc_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			scan_q <= op;
			lv_q   <= kplsc_pkg::widen_keys(key_levels);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kplsc_pkg::NUM_KEYS; i++) begin
				cnt_q[i] <= '0;
			end
			armed_q  <= '1;
			last_p_q <= '0;
			last_l_q <= '0;
			timer_q  <= '0;
		end else if (ctl.step) begin
			cnt_q[ctl.key]    <= ku.cnt;
			armed_q[ctl.key]  <= ku.armed;
			last_p_q[ctl.key] <= ku.last_p;
			last_l_q[ctl.key] <= ku.last_l;
			if (ku.reload) timer_q <= cfg_q.repeat_delay;
			else if (!scan_q && ctl.last && timer_q != '0) timer_q <= timer_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			pressed_mask <= kplsc_pkg::narrow_keys(last_p_q);
			long_mask    <= kplsc_pkg::narrow_keys(last_l_q);
		end
	end

	a_walk_starts_at_first_key: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> ctl.key == '0)
		else $error("key walk did not restart at the first key");

	a_result_only_for_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> scan_q)
		else $error("result loaded for a tick transaction");

	a_scan_never_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && scan_q && !ki.armed) |-> !ku.armed)
		else $error("scan re-armed a key");

	a_tick_gives_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && ctl.last && !scan_q) |=> !$rose(out_valid))
		else $error("tick transaction produced a result");

endmodule
